[hdl/fvang_pkg.sv]
`timescale 1ns / 1ps

package fvang_pkg;

    // Field widths
    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int ITERATIONS  = 16;

    // Internal formats
    localparam int TURN_W    = 32;                      // angle accumulator, 2^32 per turn
    localparam int CALC_W    = 64;                      // x/y datapath width
    localparam int PRE_SHIFT = 60 - COORD_WIDTH;        // magnitude alignment
    localparam int TAB_LEN   = 32;
    localparam int N_ITER    = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;
    localparam int IDX_W     = (N_ITER > 1) ? $clog2(N_ITER) : 1;

    // Stream widths, padded to whole bytes
    localparam int IN_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ANGLE_WIDTH + 7) / 8) * 8;

    // Fixed angles on the accumulator scale
    localparam logic [TURN_W-1:0] HALF_TURN    = TURN_W'(64'd1 << (TURN_W - 1));
    localparam logic [TURN_W-1:0] QUARTER_TURN = TURN_W'(64'd1 << (TURN_W - 2));

    // Rounding of the accumulator down to the output width
    localparam int RND_SHIFT = TURN_W - ANGLE_WIDTH;
    localparam logic [TURN_W:0] ROUND_ADD =
        (RND_SHIFT == 0) ? '0 : ((TURN_W + 1)'(1) << (RND_SHIFT - 1));

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [TURN_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Data handed from cell to cell
    typedef struct packed {
        logic signed [CALC_W-1:0] x;
        logic signed [CALC_W-1:0] y;
        logic [TURN_W-1:0]        z;      // rotation sum, or final angle when fixed
        logic                     x_neg;
        logic                     y_neg;
        logic                     fixed;  // axis or zero case, z already final
        logic                     zero;
    } cordic_t;

endpackage

[hdl/full_circle_vector_angle.sv]
`timescale 1ns / 1ps
// Path from input beat to result beat: one folding register,
// one register per CORDIC cell, one output register. Throughput: one beat per cycle
// when not stalled; every stage holds one beat and takes the next one as soon as
// its own beat moves on, so empty stages fill while the output stalls.
// Reset (rst_n low, asynchronous): all stage valid flags clear, pipeline empty.
module full_circle_vector_angle
    import fvang_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // x_dist, y_dist, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // angle, zero pad
    output logic                  m_tuser    // zero_vector
);

    logic                   stg_valid [N_ITER+1];
    logic                   stg_ready [N_ITER+1];
    cordic_t                stg_data  [N_ITER+1];
    logic [ANGLE_WIDTH-1:0] angle;

    // Folding stage
    fvang_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_dist    (s_tdata[COORD_WIDTH-1:0]),
        .y_dist    (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    // Chain of rotation cells
    for (genvar g = 0; g < N_ITER; g++)
    begin : g_cell
        fvang_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (IDX_W'(g)),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    // Quadrant fix-up, rounding and output register
    fvang_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stg_valid[N_ITER]),
        .in_ready    (stg_ready[N_ITER]),
        .in_data     (stg_data[N_ITER]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .angle       (angle),
        .zero_vector (m_tuser)
    );

    assign m_tdata = OUT_DATA_W'(angle);

endmodule

[hdl/fvang_prep.sv]
`timescale 1ns / 1ps

module fvang_prep
    import fvang_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] x_dist,
    input  logic signed [COORD_WIDTH-1:0] y_dist,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cordic_t                       out_data
);

    logic        valid_reg;
    cordic_t     data_reg;
    cordic_t     data_next;
    logic signed [CALC_W-1:0] x_ext;
    logic signed [CALC_W-1:0] y_ext;
    logic        x_zero;
    logic        y_zero;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Fold into the first quadrant and classify axis cases
    always_comb
    begin
        x_ext  = CALC_W'(x_dist);
        y_ext  = CALC_W'(y_dist);
        x_zero = (x_dist == '0);
        y_zero = (y_dist == '0);

        data_next.x_neg = x_dist[COORD_WIDTH-1];
        data_next.y_neg = y_dist[COORD_WIDTH-1];
        data_next.zero  = x_zero && y_zero;
        data_next.fixed = x_zero || y_zero;
        data_next.x     = (x_dist[COORD_WIDTH-1] ? -x_ext : x_ext) <<< PRE_SHIFT;
        data_next.y     = (y_dist[COORD_WIDTH-1] ? -y_ext : y_ext) <<< PRE_SHIFT;

        if (x_zero && y_zero)
        begin
            data_next.z = '0;
        end
        else if (y_zero)
        begin
            data_next.z = x_dist[COORD_WIDTH-1] ? HALF_TURN : '0;
        end
        else if (x_zero)
        begin
            data_next.z = y_dist[COORD_WIDTH-1] ? (HALF_TURN + QUARTER_TURN) : QUARTER_TURN;
        end
        else
        begin
            data_next.z = '0;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/fvang_cell.sv]
`timescale 1ns / 1ps

module fvang_cell
    import fvang_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] stage_idx,
    input  logic             in_valid,
    output logic             in_ready,
    input  cordic_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cordic_t          out_data
);

    logic        valid_reg;
    cordic_t     data_reg;
    cordic_t     data_next;
    logic signed [CALC_W-1:0] dx;
    logic signed [CALC_W-1:0] dy;
    logic [TURN_W-1:0]        step_ang;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // One vectoring micro-rotation; axis cases pass through untouched
    always_comb
    begin
        dx       = in_data.y >>> stage_idx;
        dy       = in_data.x >>> stage_idx;
        step_ang = ATAN_TAB[stage_idx];
        data_next = in_data;
        if (!in_data.fixed)
        begin
            if (!in_data.y[CALC_W-1])
            begin
                data_next.x = in_data.x + dx;
                data_next.y = in_data.y - dy;
                data_next.z = in_data.z + step_ang;
            end
            else
            begin
                data_next.x = in_data.x - dx;
                data_next.y = in_data.y + dy;
                data_next.z = in_data.z - step_ang;
            end
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/fvang_post.sv]
`timescale 1ns / 1ps

module fvang_post
    import fvang_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cordic_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ANGLE_WIDTH-1:0] angle,
    output logic                   zero_vector
);

    logic                   valid_reg;
    logic [ANGLE_WIDTH-1:0] angle_reg;
    logic [ANGLE_WIDTH-1:0] angle_next;
    logic                   zero_reg;
    logic [TURN_W-1:0]      full_ang;
    logic [TURN_W:0]        rounded;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign angle       = angle_reg;
    assign zero_vector = zero_reg;

    // Quadrant fix-up, then round half up to the output width
    always_comb
    begin
        if (in_data.fixed)
        begin
            full_ang = in_data.z;
        end
        else
        begin
            case ({in_data.x_neg, in_data.y_neg})
                2'b00:   full_ang = in_data.z;
                2'b10:   full_ang = HALF_TURN - in_data.z;
                2'b11:   full_ang = HALF_TURN + in_data.z;
                default: full_ang = '0 - in_data.z;
            endcase
        end
        rounded    = {1'b0, full_ang} + ROUND_ADD;
        angle_next = rounded[RND_SHIFT +: ANGLE_WIDTH];
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Result beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            angle_reg <= angle_next;
            zero_reg  <= in_data.zero;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fvang_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = N_ITER + 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_ITEMS    = 80;
    localparam int RANDOM_FIRST  = 800;
    localparam int RANDOM_SECOND = 760;

    typedef enum int {
        PICK_FULL,
        PICK_SMALL,
        PICK_NEAR_AXIS,
        PICK_DIAGONAL,
        PICK_EXTREME
    } vector_kind_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_SLOW,
        RDY_TOGGLE
    } ready_mode_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_dist;
        logic signed [COORD_WIDTH-1:0] y_dist;
        logic [ANGLE_WIDTH-1:0]        angle;
        logic                          zero_vector;
    } direction_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // x_dist, y_dist, zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // angle, zero pad
    logic                  m_tuser;        // zero_vector

    direction_t  expected_directions[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    bit          hold_start = 1'b0;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          mode_left = 0;
    int          toggle_phase = 0;

    full_circle_vector_angle DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Direction of (xd, yd): fold to first quadrant, CORDIC vectoring, unfold, round
    function automatic direction_t predict_direction(input logic signed [COORD_WIDTH-1:0] xd,
                                                     input logic signed [COORD_WIDTH-1:0] yd);
        direction_t               res;
        logic signed [CALC_W-1:0] xr;
        logic signed [CALC_W-1:0] yr;
        logic signed [CALC_W-1:0] dx;
        logic signed [CALC_W-1:0] dy;
        logic [TURN_W-1:0]        zr;
        logic [TURN_W-1:0]        turn;
        logic [TURN_W:0]          rounded;
        int                       i;
        res.x_dist      = xd;
        res.y_dist      = yd;
        res.zero_vector = 1'b0;
        if (xd == 0 && yd == 0)
        begin
            res.angle       = '0;
            res.zero_vector = 1'b1;
            return res;
        end
        if (yd == 0)
            turn = (xd < 0) ? HALF_TURN : '0;
        else if (xd == 0)
            turn = (yd < 0) ? HALF_TURN + QUARTER_TURN : QUARTER_TURN;
        else
        begin
            xr = CALC_W'(xd);
            yr = CALC_W'(yd);
            if (xr < 0)
                xr = -xr;
            if (yr < 0)
                yr = -yr;
            xr = xr <<< PRE_SHIFT;
            yr = yr <<< PRE_SHIFT;
            zr = '0;
            // both updates use the old x and y
            for (i = 0; i < N_ITER; i++)
            begin
                dx = yr >>> i;
                dy = xr >>> i;
                if (yr >= 0)
                begin
                    xr = xr + dx;
                    yr = yr - dy;
                    zr = zr + ATAN_TAB[i];
                end
                else
                begin
                    xr = xr - dx;
                    yr = yr + dy;
                    zr = zr - ATAN_TAB[i];
                end
            end
            if (xd > 0 && yd > 0)
                turn = zr;
            else if (xd < 0 && yd > 0)
                turn = HALF_TURN - zr;
            else if (xd < 0)
                turn = HALF_TURN + zr;
            else
                turn = '0 - zr;
        end
        // half-up rounding, a full turn wraps to 0
        rounded   = {1'b0, turn} + ROUND_ADD;
        rounded   = rounded >> RND_SHIFT;
        res.angle = rounded[ANGLE_WIDTH-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Offer one vector; sender may idle between bursts of random length
    task automatic send_vector(input logic signed [COORD_WIDTH-1:0] xd,
                               input logic signed [COORD_WIDTH-1:0] yd);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {yd, xd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_directions.push_back(predict_direction(xd, yd));
    endtask

    // Stop offering and wait for every pending result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_directions.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_vector(output logic signed [COORD_WIDTH-1:0] xd,
                               output logic signed [COORD_WIDTH-1:0] yd);
        vector_kind_t kind;
        int           roll;
        int           mag;
        logic signed [COORD_WIDTH-1:0] extremes [6];
        extremes = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
        roll = $urandom_range(0, 99);
        if (roll < 40)
            kind = PICK_FULL;
        else if (roll < 55)
            kind = PICK_SMALL;
        else if (roll < 75)
            kind = PICK_NEAR_AXIS;
        else if (roll < 85)
            kind = PICK_DIAGONAL;
        else
            kind = PICK_EXTREME;
        case (kind)
            PICK_FULL:
            begin
                xd = COORD_WIDTH'($urandom);
                yd = COORD_WIDTH'($urandom);
            end
            PICK_SMALL:
            begin
                xd = COORD_WIDTH'($signed($urandom_range(0, 16)) - 8);
                yd = COORD_WIDTH'($signed($urandom_range(0, 16)) - 8);
            end
            PICK_NEAR_AXIS:
            begin
                xd = COORD_WIDTH'($urandom);
                yd = COORD_WIDTH'($signed($urandom_range(0, 4)) - 2);
                if ($urandom_range(0, 1) == 1)
                begin
                    yd = xd;
                    xd = COORD_WIDTH'($signed($urandom_range(0, 4)) - 2);
                end
            end
            PICK_DIAGONAL:
            begin
                mag = $urandom_range(1, 32767);
                xd  = COORD_WIDTH'(($urandom_range(0, 1) == 1) ? mag : -mag);
                yd  = COORD_WIDTH'(($urandom_range(0, 1) == 1) ? mag : -mag);
            end
            default:
            begin
                xd = extremes[$urandom_range(0, 5)];
                yd = extremes[$urandom_range(0, 5)];
            end
        endcase
    endtask

    // Receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left  = $urandom_range(20, 200);
                ready_mode = ready_mode_t'($urandom_range(0, 4));
            end
            mode_left--;
            toggle_phase++;
            case (ready_mode)
                RDY_ALWAYS: m_tready <= 1'b1;
                RDY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                RDY_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
                RDY_SLOW:   m_tready <= ($urandom_range(0, 3) == 0);
                default:    m_tready <= toggle_phase[2];
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        direction_t exp_dir;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_directions.size() == 0)
                report_mismatch($sformatf("unexpected result beat angle=%0d flag=%0b",
                                          m_tdata[ANGLE_WIDTH-1:0], m_tuser));
            else
            begin
                exp_dir = expected_directions.pop_front();
                if (m_tdata[ANGLE_WIDTH-1:0] !== exp_dir.angle)
                    report_mismatch($sformatf("x=%0d y=%0d angle %0d, want %0d",
                                              exp_dir.x_dist, exp_dir.y_dist,
                                              m_tdata[ANGLE_WIDTH-1:0], exp_dir.angle));
                if (m_tuser !== exp_dir.zero_vector)
                    report_mismatch($sformatf("x=%0d y=%0d zero_vector %0b, want %0b",
                                              exp_dir.x_dist, exp_dir.y_dist,
                                              m_tuser, exp_dir.zero_vector));
            end
        end
    end

    // Zero vector and the four axes, including their extremes
    task automatic test_axis_vectors();
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sd1, 16'sd0);
        send_vector(16'sd32767, 16'sd0);
        send_vector(-16'sd1, 16'sd0);
        send_vector(-16'sd32768, 16'sd0);
        send_vector(16'sd0, 16'sd1);
        send_vector(16'sd0, 16'sd32767);
        send_vector(16'sd0, -16'sd1);
        send_vector(16'sd0, -16'sd32768);
        send_vector(16'sd0, 16'sd0);
    endtask

    // Corners in each quadrant, plus near-axis vectors
    task automatic test_corner_vectors();
        send_vector(16'sd32767, 16'sd32767);
        send_vector(-16'sd32768, 16'sd32767);
        send_vector(-16'sd32768, -16'sd32768);
        send_vector(16'sd32767, -16'sd32768);
        send_vector(16'sd1, 16'sd1);
        send_vector(-16'sd1, 16'sd1);
        send_vector(-16'sd1, -16'sd1);
        send_vector(16'sd1, -16'sd1);
        send_vector(16'sd32767, 16'sd1);
        send_vector(16'sd1, 16'sd32767);
        send_vector(-16'sd32768, -16'sd1);
        send_vector(16'sd32767, -16'sd1);
        send_vector(-16'sd1, -16'sd32768);
        send_vector(16'sd3, 16'sd4);
    endtask

    task automatic test_random_vectors(input int count);
        logic signed [COORD_WIDTH-1:0] xd;
        logic signed [COORD_WIDTH-1:0] yd;
        repeat (count)
        begin
            pick_vector(xd, yd);
            send_vector(xd, yd);
        end
    endtask

    // Receiver holds off while the sender keeps offering, filling the pipeline
    task automatic test_output_holdoff();
        hold_start = 1'b1;
        test_random_vectors(HOLD_ITEMS);
    endtask

    // Sender pauses until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        drain_results();
        test_random_vectors(40);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_axis_vectors();
        test_corner_vectors();
        test_random_vectors(RANDOM_FIRST);
        test_output_holdoff();
        test_drain_pause();
        test_random_vectors(RANDOM_SECOND);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_directions.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[full_circle_vector_angle.f]
hdl/fvang_pkg.sv
hdl/fvang_prep.sv
hdl/fvang_cell.sv
hdl/fvang_post.sv
hdl/full_circle_vector_angle.sv
bench/testbench.sv
